// ===== rtl/ordered_list_insert_remove_find_defines.svh =====
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_FIND_DEFINES_SVH
`ifndef SYNTHESIS
`define OLIRF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OLIRF_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define OLIRF_ASSERT(name, prop, msg)
`define OLIRF_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/olirf_pkg.sv =====
// Types and constants shared by the ordered list modules.
`default_nettype none
package olirf_pkg;

  localparam int unsigned OLIRF_CAPACITY   = 256;
  localparam int unsigned OLIRF_VALUE_BITS = 32;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned COUNT_W    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_REMOVE    = 3'd2,
    OP_FIND      = 3'd3,
    OP_OVERWRITE = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    op_e                   operation;
    logic [POS_W-1:0]      position;
    logic [IN_VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [IDX_W-1:0]     found_index;
    logic [COUNT_W-1:0]   count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/olirf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module olirf_ram
  import olirf_pkg::*;
#(
  parameter int unsigned WIDTH = OLIRF_VALUE_BITS,
  parameter int unsigned DEPTH = OLIRF_CAPACITY,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/olirf_ctrl.sv =====
// Sequencer: decodes an item, walks the entry memory and forms the result.
`default_nettype none
module olirf_ctrl
  import olirf_pkg::*;
#(
  parameter int unsigned CAPACITY   = OLIRF_CAPACITY,
  parameter int unsigned VALUE_BITS = OLIRF_VALUE_BITS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           res_valid_o,
  input  wire logic      res_ready_i,
  output out_item_t      res_item_o
);

`include "ordered_list_insert_remove_find_defines.svh"

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  state_e state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  rv_q, rv_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         last_q, last_d;
  op_e                   op_q, op_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  out_item_t             res_q, res_d;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata, mem_rdata;

  logic [CMPW-1:0]       pos_ext;
  logic                  pos_ok, full;
  logic [VALUE_BITS-1:0] val_in;
  logic                  accept, go_walk, issue, hit, walk_end;
  logic [CW-1:0]         ptr_dec;

  olirf_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pos_ext = CMPW'(in_item_i.position);
  assign pos_ok  = pos_ext < CMPW'(cnt_q);
  assign full    = cnt_q == CW'(CAPACITY);
  assign val_in  = VALUE_BITS'(in_item_i.value);
  assign accept  = in_valid_i && in_ready_o;
  assign ptr_dec = ptr_q - CW'(1);

  // Walk control: find and remove read upward, insert reads downward.
  always_comb begin
    issue = 1'b0;
    case (op_q)
      OP_FIND, OP_REMOVE: issue = ptr_q < cnt_q;
      OP_INSERT:          issue = ptr_q > pos_q;
      default:            issue = 1'b0;
    endcase
    hit      = rv_q && (op_q == OP_FIND) && (mem_rdata == val_q);
    issue    = issue && (state_q == S_WALK) && !hit;
    walk_end = (state_q == S_WALK) && (hit || (!issue && !rv_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = go_walk ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs, memory ports and datapath updates.
  always_comb begin
    in_ready_o  = state_q == S_IDLE;
    res_valid_o = state_q == S_DONE;
    res_item_o  = res_q;

    cnt_d  = cnt_q;
    ptr_d  = ptr_q;
    pos_d  = pos_q;
    op_d   = op_q;
    val_d  = val_q;
    res_d  = res_q;
    last_d = last_q;
    rv_d   = issue;
    go_walk = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = val_in;
    mem_re    = issue;
    mem_raddr = ptr_q[AW-1:0];

    if (op_q == OP_INSERT) begin
      mem_raddr = ptr_dec[AW-1:0];
    end
    if (issue) begin
      last_d = mem_raddr;
      ptr_d  = (op_q == OP_INSERT) ? ptr_dec : ptr_q + CW'(1);
    end

    if (accept) begin
      op_d  = in_item_i.operation;
      val_d = val_in;
      pos_d = pos_ext[CW-1:0];
      res_d = '{status: ST_OK, found: 1'b0, found_index: '0, count: COUNT_W'(cnt_q)};
      case (in_item_i.operation)
        OP_APPEND: begin
          if (val_in == '0) begin
            res_d.status = ST_ZERO;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            mem_we      = 1'b1;
            cnt_d       = cnt_q + CW'(1);
            res_d.count = COUNT_W'(cnt_d);
          end
        end
        OP_INSERT: begin
          if (!pos_ok) begin
            res_d.status = ST_RANGE;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            go_walk = 1'b1;
            ptr_d   = cnt_q;
          end
        end
        OP_REMOVE: begin
          if (!pos_ok) begin
            res_d.status = ST_RANGE;
          end else begin
            go_walk = 1'b1;
            ptr_d   = pos_ext[CW-1:0] + CW'(1);
          end
        end
        OP_FIND: begin
          go_walk = 1'b1;
          ptr_d   = '0;
        end
        OP_OVERWRITE: begin
          if (!pos_ok) begin
            res_d.status = ST_RANGE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_ext[AW-1:0];
          end
        end
        OP_CLEAR: begin
          cnt_d       = '0;
          res_d.count = '0;
        end
        default: ;
      endcase
    end

    if (state_q == S_WALK) begin
      mem_wdata = mem_rdata;
      // Move the entry just read one place along.
      if (rv_q && (op_q == OP_REMOVE)) begin
        mem_we    = 1'b1;
        mem_waddr = last_q - AW'(1);
      end
      if (rv_q && (op_q == OP_INSERT)) begin
        mem_we    = 1'b1;
        mem_waddr = last_q + AW'(1);
      end
      if (walk_end) begin
        res_d.status      = ST_OK;
        res_d.found       = hit;
        res_d.found_index = hit ? IDX_W'(last_q) : '0;
        case (op_q)
          OP_INSERT: begin
            // Drop the new value into the opened slot.
            mem_we    = 1'b1;
            mem_waddr = pos_q[AW-1:0];
            mem_wdata = val_q;
            cnt_d     = cnt_q + CW'(1);
          end
          OP_REMOVE: cnt_d = cnt_q - CW'(1);
          default:   cnt_d = cnt_q;
        endcase
        res_d.count = COUNT_W'(cnt_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    op_q   <= op_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

  `OLIRF_ASSERT_NEVER(a_cnt_bound, cnt_q > CW'(CAPACITY), "entry count above capacity")
  `OLIRF_ASSERT(a_read_in_walk, mem_re |-> (state_q == S_WALK), "memory read outside walk")
  `OLIRF_ASSERT(a_rdata_follows_read, rv_q |-> $past(mem_re), "read data without read")
  `OLIRF_ASSERT(a_walk_write_bound, (mem_we && (state_q == S_WALK)) |-> (CW'(mem_waddr) <= cnt_q), "walk write beyond count")

endmodule
`default_nettype wire

// ===== rtl/ordered_list_insert_remove_find.sv =====
// Ordered list of handle values: top level with the result output register.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one transfer carries an
// operation (append, insert, remove, find, overwrite, clear), a position
// and a value. Output channel (out_valid_o/out_ready_i/out_item_o): one
// transfer per input item with status, find result and entry count.
// Items are handled one at a time. Append, overwrite, clear and every
// rejected item are done without a walk of the entry memory. Find reads
// the entries one per cycle from index 0 and stops at the first match.
// Remove shifts count - position - 1 entries down; insert shifts count -
// position entries up. The entry memory moves one entry a cycle, so a
// find miss on a full list is the worst case. The block is ready for the
// next item as soon as the result enters the output register.
// Reset empties the list (count zero); no clearing pass runs, since only
// entries below the count are ever read. A stalled receiver holds the
// result in the output register; the block still accepts and works on the
// next item and holds that result until the register frees.
`default_nettype none
module ordered_list_insert_remove_find
  import olirf_pkg::*;
#(
  parameter int unsigned CAPACITY   = OLIRF_CAPACITY,
  parameter int unsigned VALUE_BITS = OLIRF_VALUE_BITS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

`include "ordered_list_insert_remove_find_defines.svh"

  logic      res_valid, res_ready;
  out_item_t res_item;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  olirf_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  // The output register takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // One item in flight: ready drops right after an input transfer.
  `OLIRF_ASSERT(a_single_item, (in_valid_i && in_ready_o) |=> !in_ready_o, "item taken while busy")
  // Hold a stalled result, valid and payload alike.
  `OLIRF_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o, "stalled result dropped")
  `OLIRF_ASSERT(a_out_stable, (out_valid_o && !out_ready_i) |=> $stable(out_item_o), "result moved")

endmodule
`default_nettype wire
